>>> rtl/ptsd_pkg.sv
package ptsd_pkg;

  // Default geometry: Q10.10 coordinates, 24 fraction bits on s and t
  localparam int COORD_BITS_DEF      = 20;
  localparam int PARAM_FRAC_BITS_DEF = 24;

  // Remainder width of the s/t dividers at the default coordinate width
  localparam int DIV_W_DEF = 2 * (2 * (COORD_BITS_DEF + 1) + 2) + 2;

  // Source of one barycentric parameter at the end of the divider pipe
  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_ONE,
    SEL_QA,
    SEL_QB,
    SEL_CMPA
  } sel_t;

endpackage

>>> rtl/ptsd_in_if.sv
interface ptsd_in_if #(
  parameter int COORD_BITS = ptsd_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] vertex0_x;
  logic signed [COORD_BITS-1:0] vertex0_y;
  logic signed [COORD_BITS-1:0] vertex0_z;
  logic signed [COORD_BITS-1:0] vertex1_x;
  logic signed [COORD_BITS-1:0] vertex1_y;
  logic signed [COORD_BITS-1:0] vertex1_z;
  logic signed [COORD_BITS-1:0] vertex2_x;
  logic signed [COORD_BITS-1:0] vertex2_y;
  logic signed [COORD_BITS-1:0] vertex2_z;

  modport source (
    output valid, point_x, point_y, point_z,
    output vertex0_x, vertex0_y, vertex0_z,
    output vertex1_x, vertex1_y, vertex1_z,
    output vertex2_x, vertex2_y, vertex2_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z,
    input  vertex0_x, vertex0_y, vertex0_z,
    input  vertex1_x, vertex1_y, vertex1_z,
    input  vertex2_x, vertex2_y, vertex2_z,
    output ready
  );
endinterface

interface ptsd_out_if #(
  parameter int COORD_BITS = ptsd_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [2*COORD_BITS+3:0]      sqr_distance;
  logic signed [COORD_BITS-1:0] closest_x;
  logic signed [COORD_BITS-1:0] closest_y;
  logic signed [COORD_BITS-1:0] closest_z;
  logic                         degenerate;

  modport source (
    output valid, sqr_distance, closest_x, closest_y, closest_z, degenerate,
    input  ready
  );

  modport sink (
    input  valid, sqr_distance, closest_x, closest_y, closest_z, degenerate,
    output ready
  );
endinterface

>>> rtl/ptsd_div.sv
// Pipelined restoring divider: quo = floor(num * 2^F / den), saturating at
// 2^F when num >= den. One quotient bit per stage, F+1 register stages.
module ptsd_div #(
  parameter int DW = ptsd_pkg::DIV_W_DEF,
  parameter int F  = ptsd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [F:0]    quo
);

  logic [DW-1:0] rem_r [0:F];
  logic [DW-1:0] den_r [0:F];
  logic [F-1:0]  q_r   [0:F];
  logic          one_r [0:F];

  logic [DW:0]   rem2    [1:F];
  logic          ge      [1:F];
  logic [DW-1:0] rem_nxt [1:F];
  logic [F-1:0]  q_nxt   [1:F];

  // one trial subtraction per stage
  always_comb begin
    for (int i = 1; i <= F; i++) begin
      rem2[i] = {rem_r[i-1], 1'b0};
      ge[i]   = rem2[i] >= {1'b0, den_r[i-1]};
      if (ge[i]) begin
        rem_nxt[i] = rem2[i][DW-1:0] - den_r[i-1];
      end else begin
        rem_nxt[i] = rem2[i][DW-1:0];
      end
      q_nxt[i] = {q_r[i-1][F-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      one_r[0] <= num >= den;
      for (int i = 1; i <= F; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_r[i-1];
        q_r[i]   <= q_nxt[i];
        one_r[i] <= one_r[i-1];
      end
    end
  end

  assign quo = one_r[F] ? {1'b1, {F{1'b0}}} : {1'b0, q_r[F]};

endmodule

>>> rtl/point_triangle_sqr_distance.sv
// Closest point on a triangle to a query point, and its squared distance.
// Fully pipelined: one item is taken every cycle unless a stalled output
// holds the pipe. Seven stages form the edge Gram terms, the determinant
// and the region choice, the two s/t dividers add PARAM_FRAC_BITS + 1
// stages (one quotient bit per stage), and four more stages build the
// rounded point and the distance. The whole pipe advances together; a
// stalled output freezes it and in_if.ready follows out_if.ready while
// the last stage is full.
module point_triangle_sqr_distance #(
  parameter int COORD_BITS      = ptsd_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = ptsd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptsd_in_if.sink     in_if,
  ptsd_out_if.source  out_if
);
  import ptsd_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int EW  = CW + 1;           // edge / offset components
  localparam int GW  = 2 * EW + 2;       // Gram terms
  localparam int HW  = (GW + 1) / 2;     // low half of a split Gram term
  localparam int PPW = 2 * HW + 2;       // partial product
  localparam int PW  = 2 * GW + 2;       // det, S, T
  localparam int DW  = PW;               // divider remainder
  localparam int QGW = GW + 2;           // edge numerators and denominator
  localparam int QW  = F + 1;            // s, t
  localparam int MW  = QW + 1 + EW;      // s*e product
  localparam int AW  = CW + F + 4;       // point accumulator
  localparam int SQW = 2 * CW + 4;
  localparam int NV  = F + 12;           // pipeline depth

  typedef struct packed {
    logic [2:0][CW-1:0] v0;
    logic [2:0][CW-1:0] p;
    logic [2:0][EW-1:0] e0;
    logic [2:0][EW-1:0] e1;
    sel_t               s_sel;
    sel_t               t_sel;
    logic               deg;
  } ctx_t;

  typedef struct packed {
    logic signed [PPW-1:0] hh;
    logic signed [PPW-1:0] hl;
    logic signed [PPW-1:0] lh;
    logic signed [PPW-1:0] ll;
  } pp_t;

  // four half-width partial products of a signed Gram-term product
  function automatic pp_t split_mul(logic signed [GW-1:0] a, logic signed [GW-1:0] b);
    pp_t r;
    logic signed [HW:0]      al;
    logic signed [HW:0]      bl;
    logic signed [GW-HW-1:0] ah;
    logic signed [GW-HW-1:0] bh;
    al   = $signed({1'b0, a[HW-1:0]});
    bl   = $signed({1'b0, b[HW-1:0]});
    ah   = a[GW-1:HW];
    bh   = b[GW-1:HW];
    r.hh = ah * bh;
    r.hl = ah * bl;
    r.lh = al * bh;
    r.ll = al * bl;
    return r;
  endfunction

  function automatic logic signed [PW-1:0] join_pp(pp_t x);
    logic signed [PW-1:0] mid;
    mid = PW'(x.hl) + PW'(x.lh);
    return PW'(x.ll) + (mid <<< HW) + (PW'(x.hh) <<< (2 * HW));
  endfunction

  logic adv;
  logic [NV-1:0] vld_r;

  // pipe advances unless the result stage holds an untaken item
  assign adv         = !vld_r[NV-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_if.valid};
    end
  end

  // stage 1: edges and point offset
  logic signed [CW-1:0] p_in [3];
  logic signed [CW-1:0] v0_in [3];
  logic signed [CW-1:0] v1_in [3];
  logic signed [CW-1:0] v2_in [3];

  assign p_in  = '{in_if.point_x, in_if.point_y, in_if.point_z};
  assign v0_in = '{in_if.vertex0_x, in_if.vertex0_y, in_if.vertex0_z};
  assign v1_in = '{in_if.vertex1_x, in_if.vertex1_y, in_if.vertex1_z};
  assign v2_in = '{in_if.vertex2_x, in_if.vertex2_y, in_if.vertex2_z};

  ctx_t ctx_r [0:6];
  ctx_t ctx7_nxt;
  logic signed [EW-1:0] d1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ctx_r[0].v0[k] <= v0_in[k];
        ctx_r[0].p[k]  <= p_in[k];
        ctx_r[0].e0[k] <= EW'(v1_in[k]) - EW'(v0_in[k]);
        ctx_r[0].e1[k] <= EW'(v2_in[k]) - EW'(v0_in[k]);
        d1_r[k]        <= EW'(v0_in[k]) - EW'(p_in[k]);
      end
      ctx_r[0].s_sel <= SEL_ZERO;
      ctx_r[0].t_sel <= SEL_ZERO;
      ctx_r[0].deg   <= 1'b0;
      for (int i = 1; i < 6; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
      ctx_r[6] <= ctx7_nxt;
    end
  end

  // stage 2: component products
  logic signed [2*EW-1:0] e00_r [3];
  logic signed [2*EW-1:0] e01_r [3];
  logic signed [2*EW-1:0] e11_r [3];
  logic signed [2*EW-1:0] de0_r [3];
  logic signed [2*EW-1:0] de1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e00_r[k] <= $signed(ctx_r[0].e0[k]) * $signed(ctx_r[0].e0[k]);
        e01_r[k] <= $signed(ctx_r[0].e0[k]) * $signed(ctx_r[0].e1[k]);
        e11_r[k] <= $signed(ctx_r[0].e1[k]) * $signed(ctx_r[0].e1[k]);
        de0_r[k] <= d1_r[k] * $signed(ctx_r[0].e0[k]);
        de1_r[k] <= d1_r[k] * $signed(ctx_r[0].e1[k]);
      end
    end
  end

  // stage 3: Gram terms
  logic signed [GW-1:0] a00_3_r, a01_3_r, a11_3_r, b0_3_r, b1_3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a00_3_r <= GW'(e00_r[0]) + GW'(e00_r[1]) + GW'(e00_r[2]);
      a01_3_r <= GW'(e01_r[0]) + GW'(e01_r[1]) + GW'(e01_r[2]);
      a11_3_r <= GW'(e11_r[0]) + GW'(e11_r[1]) + GW'(e11_r[2]);
      b0_3_r  <= GW'(de0_r[0]) + GW'(de0_r[1]) + GW'(de0_r[2]);
      b1_3_r  <= GW'(de1_r[0]) + GW'(de1_r[1]) + GW'(de1_r[2]);
    end
  end

  // stage 4: partial products for det, S and T
  pp_t pp4_r [6];
  logic signed [GW-1:0] a00_4_r, a01_4_r, a11_4_r, b0_4_r, b1_4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pp4_r[0] <= split_mul(a00_3_r, a11_3_r);
      pp4_r[1] <= split_mul(a01_3_r, a01_3_r);
      pp4_r[2] <= split_mul(a01_3_r, b1_3_r);
      pp4_r[3] <= split_mul(a11_3_r, b0_3_r);
      pp4_r[4] <= split_mul(a01_3_r, b0_3_r);
      pp4_r[5] <= split_mul(a00_3_r, b1_3_r);
      a00_4_r  <= a00_3_r;
      a01_4_r  <= a01_3_r;
      a11_4_r  <= a11_3_r;
      b0_4_r   <= b0_3_r;
      b1_4_r   <= b1_3_r;
    end
  end

  // stage 5: det, S, T
  logic signed [PW-1:0] det5_r, sv5_r, tv5_r;
  logic signed [GW-1:0] a00_5_r, a01_5_r, a11_5_r, b0_5_r, b1_5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      det5_r  <= join_pp(pp4_r[0]) - join_pp(pp4_r[1]);
      sv5_r   <= join_pp(pp4_r[2]) - join_pp(pp4_r[3]);
      tv5_r   <= join_pp(pp4_r[4]) - join_pp(pp4_r[5]);
      a00_5_r <= a00_4_r;
      a01_5_r <= a01_4_r;
      a11_5_r <= a11_4_r;
      b0_5_r  <= b0_4_r;
      b1_5_r  <= b1_4_r;
    end
  end

  // stage 6: |det|, S+T and the edge-region terms
  logic [PW-1:0]         det6_r;
  logic signed [PW:0]    sum6_r;
  logic signed [PW-1:0]  sv6_r, tv6_r;
  logic signed [GW-1:0]  a00_6_r, a11_6_r, b0_6_r, b1_6_r;
  logic signed [QGW-1:0] d1e_6_r, q1e_6_r, d2e_6_r, q2e_6_r, den6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      det6_r  <= det5_r[PW-1] ? PW'(-det5_r) : PW'(det5_r);
      sum6_r  <= (PW + 1)'(sv5_r) + (PW + 1)'(tv5_r);
      sv6_r   <= sv5_r;
      tv6_r   <= tv5_r;
      a00_6_r <= a00_5_r;
      a11_6_r <= a11_5_r;
      b0_6_r  <= b0_5_r;
      b1_6_r  <= b1_5_r;
      // edge V1-V2 seen from s = 0 side and from t = 0 side
      q1e_6_r <= QGW'(a11_5_r) + QGW'(b1_5_r);
      d1e_6_r <= QGW'(a11_5_r) + QGW'(b1_5_r) - QGW'(a01_5_r) - QGW'(b0_5_r);
      q2e_6_r <= QGW'(a00_5_r) + QGW'(b0_5_r);
      d2e_6_r <= QGW'(a00_5_r) + QGW'(b0_5_r) - QGW'(a01_5_r) - QGW'(b1_5_r);
      den6_r  <= QGW'(a00_5_r) - (QGW'(a01_5_r) <<< 1) + QGW'(a11_5_r);
    end
  end

  // stage 7: region choice and divider operands
  logic [DW-1:0] num_a_r, den_a_r, num_b_r, den_b_r;
  logic [DW-1:0] num_a, den_a, num_b, den_b;
  logic          in_tri;

  always_comb begin
    ctx7_nxt       = ctx_r[5];
    ctx7_nxt.s_sel = SEL_ZERO;
    ctx7_nxt.t_sel = SEL_ZERO;
    ctx7_nxt.deg   = 1'b0;
    num_a          = '0;
    den_a          = '0;
    num_b          = '0;
    den_b          = '0;
    in_tri         = !($signed({1'b0, det6_r}) < sum6_r);

    if (in_tri) begin
      if (sv6_r < 0) begin
        if (tv6_r < 0 && b0_6_r < 0) begin
          // edge V0-V1
          num_a          = DW'(-b0_6_r);
          den_a          = DW'(a00_6_r);
          ctx7_nxt.s_sel = SEL_QA;
        end else if (b1_6_r < 0) begin
          // edge V0-V2
          num_a          = DW'(-b1_6_r);
          den_a          = DW'(a11_6_r);
          ctx7_nxt.t_sel = SEL_QA;
        end
      end else if (tv6_r < 0) begin
        if (b0_6_r < 0) begin
          num_a          = DW'(-b0_6_r);
          den_a          = DW'(a00_6_r);
          ctx7_nxt.s_sel = SEL_QA;
        end
      end else if (det6_r == '0) begin
        // collapsed triangle: fall back to vertex 0
        ctx7_nxt.deg = 1'b1;
      end else begin
        num_a          = DW'(sv6_r);
        den_a          = det6_r;
        num_b          = DW'(tv6_r);
        den_b          = det6_r;
        ctx7_nxt.s_sel = SEL_QA;
        ctx7_nxt.t_sel = SEL_QB;
      end
    end else begin
      if (sv6_r < 0) begin
        if (d1e_6_r > 0) begin
          num_a          = DW'(d1e_6_r);
          den_a          = DW'(den6_r);
          ctx7_nxt.s_sel = SEL_QA;
          ctx7_nxt.t_sel = SEL_CMPA;
        end else if (q1e_6_r <= 0) begin
          ctx7_nxt.t_sel = SEL_ONE;
        end else if (b1_6_r < 0) begin
          num_a          = DW'(-b1_6_r);
          den_a          = DW'(a11_6_r);
          ctx7_nxt.t_sel = SEL_QA;
        end
      end else if (tv6_r < 0) begin
        if (d2e_6_r > 0) begin
          num_a          = DW'(d2e_6_r);
          den_a          = DW'(den6_r);
          ctx7_nxt.t_sel = SEL_QA;
          ctx7_nxt.s_sel = SEL_CMPA;
        end else if (q2e_6_r <= 0) begin
          ctx7_nxt.s_sel = SEL_ONE;
        end else if (b0_6_r < 0) begin
          num_a          = DW'(-b0_6_r);
          den_a          = DW'(a00_6_r);
          ctx7_nxt.s_sel = SEL_QA;
        end
      end else if (d1e_6_r <= 0) begin
        ctx7_nxt.t_sel = SEL_ONE;
      end else begin
        num_a          = DW'(d1e_6_r);
        den_a          = DW'(den6_r);
        ctx7_nxt.s_sel = SEL_QA;
        ctx7_nxt.t_sel = SEL_CMPA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_a_r <= num_a;
      den_a_r <= den_a;
      num_b_r <= num_b;
      den_b_r <= den_b;
    end
  end

  // dividers, with the item context riding alongside
  logic [QW-1:0] qa, qb;
  ctx_t dl_r [0:F];

  ptsd_div #(.DW(DW), .F(F)) u_div_a (
    .clk (clk),
    .en  (adv),
    .num (num_a_r),
    .den (den_a_r),
    .quo (qa)
  );

  ptsd_div #(.DW(DW), .F(F)) u_div_b (
    .clk (clk),
    .en  (adv),
    .num (num_b_r),
    .den (den_b_r),
    .quo (qb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= ctx_r[6];
      for (int i = 1; i <= F; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  // parameter select
  function automatic logic [QW-1:0] pick(sel_t sel, logic [QW-1:0] a, logic [QW-1:0] b);
    logic [QW-1:0] one;
    one = {1'b1, {F{1'b0}}};
    case (sel)
      SEL_ONE:  return one;
      SEL_QA:   return a;
      SEL_QB:   return b;
      SEL_CMPA: return one - a;
      default:  return '0;
    endcase
  endfunction

  // post stage 1: s*E0 and t*E1
  logic [QW-1:0]        s_val, t_val;
  logic signed [MW-1:0] ps1_r [3];
  logic signed [MW-1:0] pt1_r [3];
  ctx_t                 c1_r;

  assign s_val = pick(dl_r[F].s_sel, qa, qb);
  assign t_val = pick(dl_r[F].t_sel, qa, qb);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ps1_r[k] <= $signed({1'b0, s_val}) * $signed(dl_r[F].e0[k]);
        pt1_r[k] <= $signed({1'b0, t_val}) * $signed(dl_r[F].e1[k]);
      end
      c1_r <= dl_r[F];
    end
  end

  // post stage 2: accumulate and round to nearest, ties up
  logic signed [AW-1:0] acc [3];
  logic signed [CW-1:0] cp2_r [3];
  logic signed [CW-1:0] p2_r [3];
  logic                 deg2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = (AW'($signed(c1_r.v0[k])) <<< F) + AW'(ps1_r[k]) + AW'(pt1_r[k])
             + (AW'(1) <<< (F - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        cp2_r[k] <= acc[k][F +: CW];
        p2_r[k]  <= c1_r.p[k];
      end
      deg2_r <= c1_r.deg;
    end
  end

  // post stage 3: squared differences
  logic signed [CW:0]     diff [3];
  logic [2*CW+1:0]        sq3_r [3];
  logic signed [CW-1:0]   cp3_r [3];
  logic                   deg3_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (CW + 1)'(cp2_r[k]) - (CW + 1)'(p2_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq3_r[k] <= diff[k] * diff[k];
        cp3_r[k] <= cp2_r[k];
      end
      deg3_r <= deg2_r;
    end
  end

  // post stage 4: result register
  logic [SQW-1:0]       dist_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic                 deg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= SQW'(sq3_r[0]) + SQW'(sq3_r[1]) + SQW'(sq3_r[2]);
      cx_r   <= cp3_r[0];
      cy_r   <= cp3_r[1];
      cz_r   <= cp3_r[2];
      deg_r  <= deg3_r;
    end
  end

  assign out_if.valid        = vld_r[NV-1];
  assign out_if.sqr_distance = dist_r;
  assign out_if.closest_x    = cx_r;
  assign out_if.closest_y    = cy_r;
  assign out_if.closest_z    = cz_r;
  assign out_if.degenerate   = deg_r;

endmodule
